// File: hdl/rfsc_pkg.sv
// Shared types for the feedback stream cipher core: input action codes,
// result status codes, datapath micro-operations and controller/datapath links.
// No dependencies.
package rfsc_pkg;

   localparam int BYTE_W = 8;
   localparam logic [BYTE_W-1:0] PERM_LAST = 8'hFF;

   typedef enum logic [1:0] {
      ACT_KEY = 2'd0,
      ACT_ENC = 2'd1,
      ACT_DEC = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      STAT_DATA  = 2'd0,
      STAT_SCHED = 2'd1,
      STAT_NOKEY = 2'd2
   } status_type;

   // one micro-operation per cycle, issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_KEY_STORE,
      OP_INIT_FILL,
      OP_KS_READ,
      OP_KS_ACC,
      OP_KS_WR_N,
      OP_KS_WR_ACC,
      OP_KS_FINISH,
      OP_LATCH,
      OP_DS_READ_J,
      OP_DS_WR_I,
      OP_DS_OUT,
      OP_NO_KEY
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic keyed;
      logic n_last;
      logic out_free;
   } dp_stat_type;

endpackage

// File: hdl/rfsc_req_if.sv
// Request channel of the feedback stream cipher core: valid/ready plus one
// action, data byte and last flag per beat. No dependencies.
interface rfsc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] data_in;
   logic       last_byte;

   modport source (output valid, action, data_in, last_byte, input ready);
   modport sink (input valid, action, data_in, last_byte, output ready);
endinterface

// File: hdl/rfsc_rsp_if.sv
// Response channel of the feedback stream cipher core: valid/ready plus one
// ciphered byte, status code and last flag per beat. No dependencies.
interface rfsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   logic [1:0] status;
   logic       last_out;

   modport source (output valid, data_out, status, last_out, input ready);
   modport sink (input valid, data_out, status, last_out, output ready);
endinterface

// File: hdl/rfsc_datapath.sv
// Datapath of the feedback stream cipher core: permutation and key memories,
// stream indices, feedback byte and the response register. Uses rfsc_pkg.
module rfsc_datapath #(
   parameter int MAX_KEY_BYTES = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rfsc_pkg::dp_cmd_type cmd,
   output rfsc_pkg::dp_stat_type stat,
   input  logic [1:0]           req_action,
   input  logic [7:0]           req_data,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_data,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last
);
   import rfsc_pkg::*;

   localparam int CNT_W  = $clog2(MAX_KEY_BYTES + 1);
   localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam logic [CNT_W-1:0] KEY_MAX = CNT_W'(MAX_KEY_BYTES);

   logic [7:0] perm_mem [256];
   logic [7:0] key_mem [MAX_KEY_BYTES];

   logic [CNT_W-1:0]  key_count_ff, key_count_in;
   logic [KEY_AW-1:0] kidx_ff, kidx_in;
   logic [7:0]        n_ff, n_in;
   logic [7:0]        acc_ff, acc_in;
   logic [7:0]        i_ff, i_in;
   logic [7:0]        j_ff, j_in;
   logic [7:0]        fb_ff, fb_in;
   logic              keyed_ff, keyed_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [7:0]  s_hold_ff, sj_ff, t_ff, din_ff;
   logic        dec_ff, last_ff;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [7:0]  rd_a_ff, rd_b_ff, key_rd_ff;

   logic [7:0]       i_next, j_next, acc_next, t_sum, kstream, res;
   logic [CNT_W-1:0] kidx_inc;
   logic             key_room, out_free;
   logic [7:0]       addr_a, addr_b, wr_addr, wr_data;
   logic             wr_en;

   assign i_next   = i_ff + 8'd1;
   assign j_next   = j_ff + rd_a_ff;
   assign acc_next = acc_ff + key_rd_ff + rd_a_ff;
   assign t_sum    = s_hold_ff + rd_b_ff;
   assign kidx_inc = CNT_W'(kidx_ff) + CNT_W'(1);
   assign key_room = key_count_ff < KEY_MAX;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // the read of S[t] happened alongside the write of S[i]; patch both swapped entries
   assign kstream = (t_ff == j_ff) ? s_hold_ff : ((t_ff == i_ff) ? sj_ff : rd_a_ff);
   assign res     = din_ff ^ kstream ^ fb_ff;

   always_comb begin
      addr_a  = n_ff;
      addr_b  = j_next;
      wr_en   = 1'b0;
      wr_addr = n_ff;
      wr_data = n_ff;
      unique case (cmd.op)
         OP_INIT_FILL: begin
            wr_en = 1'b1;
         end
         OP_KS_ACC: begin
            addr_b = acc_next;
         end
         OP_KS_WR_N: begin
            wr_en   = 1'b1;
            wr_data = rd_b_ff;
         end
         OP_KS_WR_ACC: begin
            wr_en   = 1'b1;
            wr_addr = acc_ff;
            wr_data = s_hold_ff;
         end
         OP_LATCH: begin
            addr_a = i_next;
         end
         OP_DS_WR_I: begin
            addr_a  = t_sum;
            wr_en   = 1'b1;
            wr_addr = i_ff;
            wr_data = rd_b_ff;
         end
         OP_DS_OUT: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = s_hold_ff;
         end
         default: begin
         end
      endcase
   end

   // hold port A's read data on idle cycles so S[t] survives a response stall
   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
      if (cmd.op != OP_NONE) begin
         rd_a_ff <= perm_mem[addr_a];
      end
      rd_b_ff <= perm_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_KEY_STORE && key_room) begin
         key_mem[key_count_ff[KEY_AW-1:0]] <= req_data;
      end
      key_rd_ff <= key_mem[kidx_ff];
   end

   always_comb begin
      key_count_in  = key_count_ff;
      kidx_in       = kidx_ff;
      n_in          = n_ff;
      acc_in        = acc_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      fb_in         = fb_ff;
      keyed_in      = keyed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (cmd.op)
         OP_KEY_STORE: begin
            if (key_room) begin
               key_count_in = key_count_ff + CNT_W'(1);
            end
            kidx_in = '0;
            n_in    = '0;
            acc_in  = '0;
         end
         OP_INIT_FILL: begin
            n_in = n_ff + 8'd1;
         end
         OP_KS_ACC: begin
            acc_in = acc_next;
            if (n_ff == 8'd0) begin
               fb_in = key_rd_ff;
            end
         end
         OP_KS_WR_ACC: begin
            n_in    = n_ff + 8'd1;
            kidx_in = (kidx_inc == key_count_ff) ? '0 : kidx_inc[KEY_AW-1:0];
         end
         OP_KS_FINISH: begin
            i_in          = '0;
            j_in          = '0;
            keyed_in      = 1'b1;
            key_count_in  = '0;
            rsp_valid_in  = 1'b1;
            rsp_data_in   = '0;
            rsp_status_in = STAT_SCHED;
            rsp_last_in   = 1'b0;
         end
         OP_LATCH: begin
            i_in = i_next;
         end
         OP_DS_READ_J: begin
            j_in = j_next;
         end
         OP_DS_OUT: begin
            fb_in         = fb_ff ^ (dec_ff ? res : din_ff);
            rsp_valid_in  = 1'b1;
            rsp_data_in   = res;
            rsp_status_in = STAT_DATA;
            rsp_last_in   = last_ff;
         end
         OP_NO_KEY: begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = '0;
            rsp_status_in = STAT_NOKEY;
            rsp_last_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
         kidx_ff      <= '0;
         n_ff         <= '0;
         acc_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         fb_ff        <= '0;
         keyed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_count_ff <= key_count_in;
         kidx_ff      <= kidx_in;
         n_ff         <= n_in;
         acc_ff       <= acc_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         fb_ff        <= fb_in;
         keyed_ff     <= keyed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holding registers, no reset
   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      if (cmd.op == OP_LATCH) begin
         din_ff  <= req_data;
         dec_ff  <= (req_action == ACT_DEC);
         last_ff <= req_last;
      end
      if (cmd.op == OP_KS_ACC || cmd.op == OP_DS_READ_J) begin
         s_hold_ff <= rd_a_ff;
      end
      if (cmd.op == OP_DS_WR_I) begin
         sj_ff <= rd_b_ff;
         t_ff  <= t_sum;
      end
   end

   assign stat.keyed    = keyed_ff;
   assign stat.n_last   = (n_ff == PERM_LAST);
   assign stat.out_free = out_free;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= KEY_MAX)
      else $error("key count beyond store depth");

   a_key_index: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_KS_READ) |-> (CNT_W'(kidx_ff) < key_count_ff))
      else $error("key index outside loaded key");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DS_OUT || cmd.op == OP_KS_FINISH || cmd.op == OP_NO_KEY)
      |-> out_free)
      else $error("response overwritten before taken");

   a_finish: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_KS_FINISH) |=> (keyed_ff && key_count_ff == '0 &&
      i_ff == 8'd0 && j_ff == 8'd0 && rsp_valid_ff))
      else $error("schedule end did not settle state");

endmodule

// File: hdl/rfsc_ctrl.sv
// Controller of the feedback stream cipher core: sequences key schedule and
// data steps as micro-operations for rfsc_datapath. Uses rfsc_pkg.
module rfsc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_action,
   input  logic                  req_last,
   input  rfsc_pkg::dp_stat_type stat,
   output rfsc_pkg::dp_cmd_type  cmd
);
   import rfsc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_KR,
      S_KA,
      S_KW1,
      S_KW2,
      S_KFIN,
      S_NOKEY,
      S_DJ,
      S_WI,
      S_DOUT
   } state_type;

   state_type state_ff, state_in;
   op_type    op;

   assign req_ready = (state_ff == S_IDLE);
   assign cmd.op    = op;

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_action) inside
                  ACT_KEY: begin
                     op = OP_KEY_STORE;
                     if (req_last) begin
                        state_in = S_INIT;
                     end
                  end
                  ACT_ENC, ACT_DEC: begin
                     if (stat.keyed) begin
                        op       = OP_LATCH;
                        state_in = S_DJ;
                     end else begin
                        state_in = S_NOKEY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INIT: begin
            op = OP_INIT_FILL;
            if (stat.n_last) begin
               state_in = S_KR;
            end
         end
         S_KR: begin
            op       = OP_KS_READ;
            state_in = S_KA;
         end
         S_KA: begin
            op       = OP_KS_ACC;
            state_in = S_KW1;
         end
         S_KW1: begin
            op       = OP_KS_WR_N;
            state_in = S_KW2;
         end
         S_KW2: begin
            op       = OP_KS_WR_ACC;
            state_in = stat.n_last ? S_KFIN : S_KR;
         end
         S_KFIN: begin
            if (stat.out_free) begin
               op       = OP_KS_FINISH;
               state_in = S_IDLE;
            end
         end
         S_NOKEY: begin
            if (stat.out_free) begin
               op       = OP_NO_KEY;
               state_in = S_IDLE;
            end
         end
         S_DJ: begin
            op       = OP_DS_READ_J;
            state_in = S_WI;
         end
         S_WI: begin
            op       = OP_DS_WR_I;
            state_in = S_DOUT;
         end
         S_DOUT: begin
            if (stat.out_free) begin
               op       = OP_DS_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/rc4_feedback_stream_cipher_core.sv
// Top level of the RC4-style stream cipher with plaintext feedback.
// Depends on rfsc_pkg, rfsc_req_if, rfsc_rsp_if, rfsc_ctrl and rfsc_datapath.
//
//   channel | dir | beat payload                     | handshake
//   req_bus | in  | action, data_in, last_byte       | valid/ready
//   rsp_bus | out | data_out, status, last_out       | valid/ready
//
// A data byte runs the generator step: it reads S[i], then S[j], swaps through
// the single write port of the permutation memory and reads S[S[i]+S[j]]; the
// next request is taken only after that byte's response is posted.
// A key byte without last_byte is only stored; the closing key byte is stored,
// then the permutation is filled, then 256 schedule rounds run, and then the
// status beat is posted.
// Reset is synchronous and clears indices, feedback, key count and the keyed
// flag; the permutation and key memories are not cleared.
// A response waiting on rsp_bus holds its register; the controller stalls in
// its final step until that register is free, and takes no request meanwhile.
module rc4_feedback_stream_cipher_core #(
   parameter int MAX_KEY_BYTES = 32
) (
   input logic      clock,
   input logic      reset,
   rfsc_req_if.sink   req_bus,
   rfsc_rsp_if.source rsp_bus
);
   import rfsc_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequence the micro-operations: one per cycle
   rfsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req_action (req_bus.action),
      .req_last   (req_bus.last_byte),
      .stat       (stat),
      .cmd        (cmd)
   );

   // hold the memories, indices, feedback and the response register
   rfsc_datapath #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_action (req_bus.action),
      .req_data   (req_bus.data_in),
      .req_last   (req_bus.last_byte),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .rsp_data   (rsp_bus.data_out),
      .rsp_status (rsp_bus.status),
      .rsp_last   (rsp_bus.last_out)
   );

endmodule

// File: bench/tb_rc4_feedback_stream_cipher_core.sv
// Self-checking bench for rc4_feedback_stream_cipher_core: drives request beats,
// predicts every response in place and compares each one as it is taken.
// Depends on rfsc_pkg, rfsc_req_if, rfsc_rsp_if and the core itself.
module tb_rc4_feedback_stream_cipher_core;
   timeunit 1ns;
   timeprecision 1ps;

   import rfsc_pkg::*;

   localparam int MAX_KEYS = 32;
   localparam logic [1:0] ACT_UNUSED = 2'd3;   // no enum member: the core ignores it
   localparam int ITEM_TARGET = 550;
   localparam int REPORT_LIMIT = 10;
   localparam int LONG_HOLD = 300;             // receiver back-pressure stretch
   localparam int DRAIN_CYCLES = 16;
   // Longest quiet spell of a correct run: a full key schedule
   // behind the long hold, plus both idle gaps; allow several times that.
   localparam int WATCHDOG_LIMIT = 8000;

   typedef struct packed {
      logic [7:0] out_byte;
      status_type status;
      logic       out_last;
   } cipher_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rfsc_req_if req_bus ();
   rfsc_rsp_if rsp_bus ();

   rc4_feedback_stream_cipher_core #(
      .MAX_KEY_BYTES(MAX_KEYS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Cipher state as the bench sees it. The permutation and key store are
   // never read before they are written, so their start values do not matter.
   // ------------------------------------------------------------------
   logic [7:0] perm_mem [256];
   logic [7:0] key_mem [MAX_KEYS];
   int         key_len = 0;
   logic [7:0] gen_i = 8'h00;
   logic [7:0] gen_j = 8'h00;
   logic [7:0] chain_byte = 8'h00;
   bit         have_key = 1'b0;

   cipher_beat_type expected_beats[$];
   int  mismatch_count = 0;
   int  sent_count = 0;
   int  quiet_cycles = 0;
   bit  idle_on = 1'b1;          // shared: both sides insert random gaps
   bit  hold_off_pending = 1'b0; // ask the receiver for one long stall

   // Advance the cipher by one request beat; return 1 with the response it
   // causes, or 0 when the beat produces nothing.
   function automatic bit cipher_step(input logic [1:0] act, input logic [7:0] value,
                                      input logic last, output cipher_beat_type beat);
      logic [7:0] acc;
      logic [7:0] swap;
      logic [7:0] stream;
      beat = '{out_byte: 8'h00, status: STAT_DATA, out_last: 1'b0};
      if (act == ACT_KEY) begin
         // Drop key bytes once the store is full; the closing byte still
         // schedules over what is held.
         if (key_len < MAX_KEYS) begin
            key_mem[key_len] = value;
            key_len++;
         end
         if (!last)
            return 1'b0;
         acc = 8'h00;
         for (int n = 0; n < 256; n++)
            perm_mem[n] = 8'(n);
         for (int n = 0; n < 256; n++) begin
            acc = acc + key_mem[n % key_len] + perm_mem[n];
            swap = perm_mem[n];
            perm_mem[n] = perm_mem[acc];
            perm_mem[acc] = swap;
         end
         chain_byte = key_mem[0];
         gen_i = 8'h00;
         gen_j = 8'h00;
         have_key = 1'b1;
         key_len = 0;
         beat.status = STAT_SCHED;
         return 1'b1;
      end
      if (act == ACT_UNUSED)
         return 1'b0;
      if (!have_key) begin
         beat.status = STAT_NOKEY;
         return 1'b1;
      end
      gen_i = gen_i + 8'd1;
      gen_j = gen_j + perm_mem[gen_i];
      swap = perm_mem[gen_i];
      perm_mem[gen_i] = perm_mem[gen_j];
      perm_mem[gen_j] = swap;
      stream = perm_mem[8'(perm_mem[gen_i] + perm_mem[gen_j])];
      beat.out_byte = value ^ stream ^ chain_byte;
      // Feed back the plaintext: the input when encrypting, the output when
      // decrypting.
      chain_byte = chain_byte ^ ((act == ACT_ENC) ? value : beat.out_byte);
      beat.out_last = last;
      return 1'b1;
   endfunction

   // Offer one request beat, hold it until taken, then predict its response.
   // Call at a rising edge; valid is left high for a following beat.
   task automatic send_beat(input logic [1:0] act, input logic [7:0] value,
                            input logic last);
      int gap;
      cipher_beat_type beat;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.action    <= act;
      req_bus.data_in   <= value;
      req_bus.last_byte <= last;
      @(posedge clock iff req_bus.ready);
      if (cipher_step(act, value, last, beat))
         expected_beats.push_back(beat);
      if (act != ACT_UNUSED)
         sent_count++;
   endtask

   // ------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------

   // Data ahead of any key must come back as a no-key status and leave the
   // state untouched; the unused action must vanish without a response.
   task automatic test_no_key();
      send_beat(ACT_ENC, 8'h00, 1'b0);
      send_beat(ACT_DEC, 8'hFF, 1'b1);
      send_beat(ACT_UNUSED, 8'hFF, 1'b1);
   endtask

   // One-byte key: the closing byte is also the first, so the key index
   // wraps every round. Push both byte extremes and echo last on data.
   task automatic test_short_key();
      send_beat(ACT_KEY, 8'hFF, 1'b1);
      send_beat(ACT_ENC, 8'h00, 1'b0);
      send_beat(ACT_ENC, 8'hFF, 1'b1);
      send_beat(ACT_DEC, 8'h5A, 1'b0);
   endtask

   // Start a new key while keyed: data in between must still use the old
   // permutation until the new key closes.
   task automatic test_rekey_while_keyed();
      send_beat(ACT_KEY, 8'h01, 1'b0);
      send_beat(ACT_ENC, 8'h3C, 1'b0);
      send_beat(ACT_UNUSED, 8'h00, 1'b0);
      send_beat(ACT_KEY, 8'h80, 1'b1);
      send_beat(ACT_DEC, 8'hC3, 1'b1);
   endtask

   // Stall the response side for a long stretch while requests keep coming,
   // so the response register fills and the core stops taking requests.
   task automatic test_output_stall();
      idle_on = 1'b0;
      hold_off_pending = 1'b1;
      for (int n = 0; n < 12; n++)
         send_beat(($urandom_range(0, 1) != 0) ? ACT_DEC : ACT_ENC,
                   8'($urandom_range(0, 255)), 1'(n == 11));
      idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Random sessions: mostly a full key followed by a few messages, the rest
   // loose noise. Long keys overflow the store now and then, and stray key
   // bytes inside a message start a new key while the old one runs.
   // ------------------------------------------------------------------
   task automatic test_random_sessions();
      int key_bytes;
      int msg_bytes;
      while (sent_count < ITEM_TARGET) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) < 8) begin
            key_bytes = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 40)
                                                    : $urandom_range(1, 16);
            for (int k = 0; k < key_bytes; k++)
               send_beat(ACT_KEY, 8'($urandom_range(0, 255)), 1'(k == key_bytes - 1));
            repeat ($urandom_range(1, 3)) begin
               msg_bytes = $urandom_range(1, 24);
               for (int k = 0; k < msg_bytes; k++) begin
                  if ($urandom_range(0, 19) == 0)
                     send_beat(ACT_KEY, 8'($urandom_range(0, 255)), 1'b0);
                  send_beat(($urandom_range(0, 1) != 0) ? ACT_DEC : ACT_ENC,
                            8'($urandom_range(0, 255)), 1'(k == msg_bytes - 1));
               end
            end
         end else begin
            repeat ($urandom_range(1, 6))
               send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Response side: draw a wait per beat, then hold ready until taken.
   // Honour a long hold-off when the stall test asks for one.
   // ------------------------------------------------------------------
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         gap = idle_on ? $urandom_range(0, 7) : 0;
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock iff rsp_bus.valid && rsp_bus.ready);
      end
   end

   // Compare every response beat with the oldest prediction.
   always @(posedge clock) begin
      cipher_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_beats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected beat data_out=%02h status=%0d last_out=%0b",
                        $time, rsp_bus.data_out, rsp_bus.status, rsp_bus.last_out);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_bus.data_out !== want.out_byte || rsp_bus.status !== want.status ||
                rsp_bus.last_out !== want.out_last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"%0t: mismatch exp data_out=%02h status=%0d last_out=%0b,",
                            " got %02h %0d %0b"},
                           $time, want.out_byte, want.status, want.out_last,
                           rsp_bus.data_out, rsp_bus.status, rsp_bus.last_out);
            end
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Sequence: reset, directed tests, random sessions, drain, verdict.
   // ------------------------------------------------------------------
   initial begin
      req_bus.valid     <= 1'b0;
      req_bus.action    <= ACT_KEY;
      req_bus.data_in   <= 8'h00;
      req_bus.last_byte <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_no_key();
      test_short_key();
      test_rekey_while_keyed();
      test_output_stall();
      test_random_sessions();

      // Drop valid once the final beat is taken, then let responses drain.
      req_bus.valid <= 1'b0;
      while (expected_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: filelist.f
hdl/rfsc_pkg.sv
hdl/rfsc_req_if.sv
hdl/rfsc_rsp_if.sv
hdl/rfsc_datapath.sv
hdl/rfsc_ctrl.sv
hdl/rc4_feedback_stream_cipher_core.sv
bench/tb_rc4_feedback_stream_cipher_core.sv
